### hw/rtl/bits_pkg.sv
// ---------------------------------------------------------------------------
// bits_pkg
// Shared codes and constants of the ball-in-tube physics step, and a saturation function.
// ---------------------------------------------------------------------------
package bits_pkg;

    localparam int W = 32;
    localparam int FRAC = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [W-1:0] WMAX = 32'sh7FFF_FFFF;
    localparam logic signed [W-1:0] WMIN = 32'sh8000_0000;
    localparam logic signed [W-1:0] ONE_Q = 32'sh0001_0000;
    // round(9.8 * 2^16)
    localparam logic signed [W-1:0] G_Q = 32'sd642253;
    // ceil(2^31 / 49), exact floor division by 49 below 2^25
    localparam logic [25:0] KG_RECIP = 26'd43826197;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAVITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REBOUND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MU = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REST = 3'd5;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // saturate a wide signed value to the word
    function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
        logic signed [W+1:0] hi;
        logic signed [W+1:0] lo;
        begin
            hi = (W+2)'(WMAX);
            lo = (W+2)'(WMIN);
            if (v > hi)
            begin
                sat_w = WMAX;
            end
            else if (v < lo)
            begin
                sat_w = WMIN;
            end
            else
            begin
                sat_w = v[W-1:0];
            end
        end
    endfunction

endpackage

### hw/rtl/bits_if.sv
// ---------------------------------------------------------------------------
// bits_if
// Channel interfaces: input items, result items and register writes.
// ---------------------------------------------------------------------------
interface bits_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic [15:0] time_step;
    logic signed [17:0] tilt_sine;
    logic signed [31:0] linear_accel;
    modport source (output valid, operation, time_step, tilt_sine, linear_accel, input ready);
    modport sink (input valid, operation, time_step, tilt_sine, linear_accel, output ready);
endinterface

interface bits_out_if;
    logic valid;
    logic ready;
    logic impact;
    logic impact_at_left;
    logic [30:0] impact_speed;
    logic [23:0] position;
    logic signed [31:0] velocity;
    modport source (output valid, impact, impact_at_left, impact_speed, position, velocity,
                    input ready);
    modport sink (input valid, impact, impact_at_left, impact_speed, position, velocity,
                  output ready);
endinterface

interface bits_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/ball_in_tube_physics_step.sv
// ---------------------------------------------------------------------------
// ball_in_tube_physics_step
// Fixed-point ball-in-tube simulator, one tick or restart per input item.
// ---------------------------------------------------------------------------
// path: a restart goes straight to the output state; a tick rolls or slides, then
//   runs the velocity, position and wall steps, plus a rebound step on a bounce
// throughput: one item at a time, set by the shared 32x32 multiplier (one
//   product a cycle) and the 24-step bit-pair square root sequence
// reset: registers take their listed reset values, ball at half the cavity
// result waits in an output register; the next item is taken meanwhile
module ball_in_tube_physics_step
    import bits_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bits_in_if.sink    in_ch,
    bits_out_if.source out_ch,
    bits_cfg_if.sink   cfg
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_ROLL1 = 14'b00000000000010,
        S_ROLL2 = 14'b00000000000100,
        S_SL1   = 14'b00000000001000,
        S_SQRT  = 14'b00000000010000,
        S_SL2   = 14'b00000000100000,
        S_SL3   = 14'b00000001000000,
        S_SL4   = 14'b00000010000000,
        S_SL5   = 14'b00000100000000,
        S_VEL   = 14'b00001000000000,
        S_POS   = 14'b00010000000000,
        S_WALL  = 14'b00100000000000,
        S_BNC   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg;

    // configuration
    logic [23:0] cav_reg;
    logic mode_reg, reb_reg;
    logic [21:0] gain_reg;
    logic [17:0] mu_reg;
    logic [16:0] rest_reg;

    // physics state
    logic signed [W-1:0] pos_reg, vel_reg, pacc_reg;
    logic rl_reg, rr_reg;

    // item and working registers
    logic [15:0] dt_reg;
    logic signed [W-1:0] s_reg, lin_reg, acc_reg, vn_reg, t0_reg, t1_reg, m_reg, kg_reg;
    logic [3:0] step_reg;
    logic [4:0] sq_cnt_reg;
    logic [33:0] sq_rem_reg;
    logic [16:0] sq_root_reg;
    logic [47:0] sq_n_reg;
    logic imp_reg, left_reg;
    logic [30:0] spd_reg;

    // output register
    logic ov_reg;
    logic oimp_reg, oleft_reg;
    logic [30:0] ospd_reg;
    logic [23:0] opos_reg;
    logic signed [31:0] ovel_reg;

    // shared multiplier: truncating magnitude product, signed, saturated
    logic signed [W-1:0] ma, mb, mp;
    logic ma_neg, mb_neg;
    logic [W-1:0] ua, ub;
    logic [2*W-1:0] up;
    logic [2*W-FRAC-1:0] ur;
    always_comb
    begin
        ma_neg = ma[W-1];
        mb_neg = mb[W-1];
        ua = ma_neg ? W'(-ma) : ma;
        ub = mb_neg ? W'(-mb) : mb;
        up = ua * ub;
        ur = up[2*W-1:FRAC];
        if (ma_neg != mb_neg)
        begin
            if (ur > (2*W-FRAC)'({1'b1, {(W-1){1'b0}}}))
            begin
                mp = WMIN;
            end
            else
            begin
                mp = W'(-ur[W-1:0]);
            end
        end
        else if (ur > (2*W-FRAC)'(WMAX))
        begin
            mp = WMAX;
        end
        else
        begin
            mp = ur[W-1:0];
        end
    end

    // derived constants for this item
    logic signed [W-1:0] gain_w, kg_w, mu_w, e_w, cav_w;
    logic [25:0] kg_num;
    logic [50:0] kg_prod;
    always_comb
    begin
        gain_w = W'($signed({1'b0, gain_reg}));
        // (10 * gain + 49) / 98 as ((10 * gain + 49) / 2) / 49, reciprocal multiply
        kg_num = 26'(gain_reg) * 26'd10 + 26'd49;
        kg_prod = 51'(kg_num[25:1]) * 51'(KG_RECIP);
        kg_w = W'(kg_prod[50:31]);
        mu_w = W'($signed({1'b0, mu_reg}));
        e_w = W'($signed({1'b0, rest_reg}));
        cav_w = W'($signed({1'b0, cav_reg}));
    end

    // multiplier operand selection
    logic signed [W-1:0] half_a, half_v;
    logic signed [W:0] sum_a, sum_v;
    always_comb
    begin
        sum_a = (W+1)'(pacc_reg) + (W+1)'(acc_reg);
        sum_v = (W+1)'(vel_reg) + (W+1)'(vn_reg);
        half_a = sum_a[W:1];
        half_v = sum_v[W:1];
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_ROLL1: begin ma = gain_w; mb = s_reg; end
            S_ROLL2: begin ma = kg_reg; mb = lin_reg; end
            S_SL1:
            begin
                if (step_reg == 4'd0)
                begin
                    ma = s_reg; mb = s_reg;
                end
                else
                begin
                    ma = mu_w; mb = mu_w;
                end
            end
            S_SL2: begin ma = t1_reg; mb = m_reg; end
            S_SL3: begin ma = G_Q; mb = mu_w; end
            S_SL4: begin ma = t1_reg; mb = s_reg[W-1] ? -t0_reg : t0_reg; end
            S_SL5: begin ma = G_Q; mb = s_reg; end
            S_VEL: begin ma = W'($signed({1'b0, dt_reg})); mb = half_a; end
            S_POS: begin ma = W'($signed({1'b0, dt_reg})); mb = half_v; end
            S_BNC: begin ma = e_w; mb = W'(spd_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_ch.valid = ov_reg;
    assign out_ch.impact = oimp_reg;
    assign out_ch.impact_at_left = oleft_reg;
    assign out_ch.impact_speed = ospd_reg;
    assign out_ch.position = opos_reg;
    assign out_ch.velocity = ovel_reg;

    // square root step values
    logic [33:0] sq_trial;
    logic [35:0] sq_rem_sh;
    always_comb
    begin
        sq_rem_sh = {sq_rem_reg, sq_n_reg[47:46]};
        sq_trial = 34'({sq_root_reg, 2'b01});
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cav_reg <= 24'd65536;
            mode_reg <= 1'b0;
            reb_reg <= 1'b1;
            gain_reg <= 22'd458752;
            mu_reg <= 18'd19661;
            rest_reg <= 17'd32768;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CAVITY: cav_reg <= cfg.data[23:0];
                REG_MODE: mode_reg <= cfg.data[0];
                REG_REBOUND: reb_reg <= cfg.data[0];
                REG_GAIN: gain_reg <= cfg.data[21:0];
                REG_MU: mu_reg <= cfg.data[17:0];
                REG_REST: rest_reg <= cfg.data[16:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg <= W'(32'd32768);
            vel_reg <= '0;
            pacc_reg <= '0;
            rl_reg <= 1'b0;
            rr_reg <= 1'b0;
            ov_reg <= 1'b0;
            step_reg <= '0;
            sq_cnt_reg <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        dt_reg <= in_ch.time_step;
                        s_reg <= W'(in_ch.tilt_sine);
                        lin_reg <= in_ch.linear_accel;
                        imp_reg <= 1'b0;
                        left_reg <= 1'b0;
                        spd_reg <= '0;
                        step_reg <= '0;
                        if (in_ch.operation == OP_RESTART)
                        begin
                            pos_reg <= W'(cav_reg[23:1]);
                            vel_reg <= '0;
                            vn_reg <= '0;
                            pacc_reg <= '0;
                            rl_reg <= 1'b0;
                            rr_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= mode_reg ? S_SL1 : S_ROLL1;
                        end
                    end
                end
                S_ROLL1:
                begin
                    t0_reg <= mp;
                    kg_reg <= kg_w;
                    state_reg <= S_ROLL2;
                end
                S_ROLL2:
                begin
                    acc_reg <= sat_w((W+2)'(t0_reg) - (W+2)'(mp));
                    state_reg <= S_VEL;
                end
                S_SL1:
                begin
                    if (step_reg == 4'd0)
                    begin
                        // s2 and m = max(1 - s2, 0)
                        t0_reg <= mp;
                        if (mp >= ONE_Q)
                        begin
                            m_reg <= '0;
                            sq_n_reg <= '0;
                        end
                        else
                        begin
                            m_reg <= ONE_Q - mp;
                            sq_n_reg <= {W'(ONE_Q - mp), 16'd0};
                        end
                        step_reg <= 4'd1;
                    end
                    else
                    begin
                        t1_reg <= mp;
                        sq_rem_reg <= '0;
                        sq_root_reg <= '0;
                        sq_cnt_reg <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    // one result bit a cycle
                    if (sq_rem_sh >= 36'(sq_trial))
                    begin
                        sq_rem_reg <= 34'(sq_rem_sh - 36'(sq_trial));
                        sq_root_reg <= {sq_root_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg <= sq_rem_sh[33:0];
                        sq_root_reg <= {sq_root_reg[15:0], 1'b0};
                    end
                    sq_n_reg <= {sq_n_reg[45:0], 2'b00};
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    if (sq_cnt_reg == 5'd23)
                    begin
                        state_reg <= S_SL2;
                    end
                end
                S_SL2:
                begin
                    // stiction: s2 <= mu^2 * m
                    if (t0_reg <= mp)
                    begin
                        acc_reg <= sat_w(-(W+2)'(lin_reg));
                        state_reg <= S_VEL;
                    end
                    else
                    begin
                        t0_reg <= W'(sq_root_reg);
                        state_reg <= S_SL3;
                    end
                end
                S_SL3:
                begin
                    t1_reg <= mp;
                    state_reg <= S_SL4;
                end
                S_SL4:
                begin
                    t1_reg <= mp;
                    state_reg <= S_SL5;
                end
                S_SL5:
                begin
                    acc_reg <= sat_w((W+2)'(sat_w((W+2)'(mp) - (W+2)'(t1_reg)))
                                     - (W+2)'(lin_reg));
                    state_reg <= S_VEL;
                end
                S_VEL:
                begin
                    vn_reg <= sat_w((W+2)'(vel_reg) + (W+2)'(mp));
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    t0_reg <= sat_w((W+2)'(pos_reg) + (W+2)'(mp));
                    pacc_reg <= acc_reg;
                    state_reg <= S_WALL;
                end
                S_WALL:
                begin
                    state_reg <= S_OUT;
                    if (t0_reg <= 0)
                    begin
                        if (vn_reg < 0)
                        begin
                            if (!rl_reg && reb_reg)
                            begin
                                imp_reg <= 1'b1;
                                left_reg <= 1'b1;
                                spd_reg <= (vn_reg == WMIN) ? 31'h7FFF_FFFF : 31'(-vn_reg);
                                state_reg <= S_BNC;
                            end
                            else
                            begin
                                vn_reg <= '0;
                            end
                        end
                        pos_reg <= '0;
                        rl_reg <= 1'b1;
                        rr_reg <= 1'b0;
                    end
                    else if (t0_reg >= cav_w)
                    begin
                        if (vn_reg > 0)
                        begin
                            if (!rr_reg && reb_reg)
                            begin
                                imp_reg <= 1'b1;
                                spd_reg <= 31'(vn_reg);
                                state_reg <= S_BNC;
                            end
                            else
                            begin
                                vn_reg <= '0;
                            end
                        end
                        pos_reg <= cav_w;
                        rr_reg <= 1'b1;
                        rl_reg <= 1'b0;
                    end
                    else
                    begin
                        pos_reg <= t0_reg;
                        rl_reg <= 1'b0;
                        rr_reg <= 1'b0;
                    end
                end
                S_BNC:
                begin
                    if (left_reg)
                    begin
                        vn_reg <= mp;
                    end
                    else
                    begin
                        vn_reg <= sat_w(-(W+2)'(mp));
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // commit velocity once the output register is free
                    if (!ov_reg)
                    begin
                        ov_reg <= 1'b1;
                        vel_reg <= vn_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && !ov_reg)
        begin
            oimp_reg <= imp_reg;
            oleft_reg <= left_reg;
            ospd_reg <= spd_reg;
            if (pos_reg[W-1])
            begin
                opos_reg <= '0;
            end
            else if (|pos_reg[W-2:24])
            begin
                opos_reg <= 24'hFF_FFFF;
            end
            else
            begin
                opos_reg <= pos_reg[23:0];
            end
            ovel_reg <= vn_reg;
        end
    end

endmodule

### verif/bits_tb_if.sv
// ---------------------------------------------------------------------------
// bits_tb_if
// Testbench-side note: the channel interfaces come from the rtl folder.
// ---------------------------------------------------------------------------
// this file only holds a small helper package shared by the testbench
package tb_ball_pkg;

    // one input item as the testbench keeps it
    typedef struct packed {
        logic               operation;
        logic [15:0]        time_step;
        logic signed [17:0] tilt_sine;
        logic signed [31:0] linear_accel;
    } tick_item_t;

    // one result item
    typedef struct packed {
        logic               impact;
        logic               impact_at_left;
        logic [30:0]        impact_speed;
        logic [23:0]        position;
        logic signed [31:0] velocity;
    } ball_state_t;

endpackage

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the ball-in-tube physics step.
// Drives restart and tick items with random gaps, computes the expected
// position, velocity and impact report in a fixed-point predictor, and
// compares every result item in order. Registers change between phases.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bits_pkg::*;
    import tb_ball_pkg::*;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam longint ONE_I = 64'sd65536;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    logic clk;
    logic rst_n;

    bits_in_if  in_ch ();
    bits_out_if out_ch ();
    bits_cfg_if cfg ();

    ball_in_tube_physics_step i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // predictor registers and ball state
    longint cav_len, mode_sel, bounce_en, gain_reg, mu_reg, rest_reg;
    longint ball_pos, ball_vel, last_accel;
    bit     rest_l, rest_r;

    tick_item_t  pending_items[$];
    ball_state_t expected_states[$];
    int          fail_count = 0;
    int          long_hold = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    bit          idle_off;
    int          send_gap;
    int          recv_gap;

    // clock
    initial
    begin
        clk = 1'b0;
    end
    always #10 clk = ~clk;

    function automatic longint clamp_w(longint v);
        if (v > SMAX)
        begin
            return SMAX;
        end
        if (v < SMIN)
        begin
            return SMIN;
        end
        return v;
    endfunction

    function automatic longint half_floor(longint v);
        return v >>> 1;
    endfunction

    // q16 product, magnitude truncated, then saturated
    function automatic longint qmul(longint a, longint b);
        bit              neg;
        logic [127:0]    mag;
        logic [127:0]    lim;
        neg = (a < 0) != (b < 0);
        mag = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        mag = mag >> 16;
        lim = neg ? 128'(SMAX) + 1 : 128'(SMAX);
        if (mag > lim)
        begin
            mag = lim;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void restart_ball();
        ball_pos = cav_len >>> 1;
        ball_vel = 0;
        last_accel = 0;
        rest_l = 1'b0;
        rest_r = 1'b0;
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg.index <= idx;
        cfg.data <= value;
        cfg.valid <= 1'b1;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid <= 1'b0;
        case (idx)
            REG_CAVITY:  cav_len = value & 32'hFFFFFF;
            REG_MODE:    mode_sel = value & 1;
            REG_REBOUND: bounce_en = value & 1;
            REG_GAIN:    gain_reg = value & 32'h3FFFFF;
            REG_MU:      mu_reg = value & 32'h3FFFF;
            REG_REST:    rest_reg = value & 32'h1FFFF;
            default:     ;
        endcase
    endtask

    // physics step prediction for one accepted item
    function automatic ball_state_t step_ball(tick_item_t it);
        ball_state_t r;
        longint dt, s, lin, a, v, x, kg, s2, m, c, g, fc, spd;
        r = '0;
        spd = 0;
        if (it.operation == OP_RESTART)
        begin
            restart_ball();
        end
        else
        begin
            dt = it.time_step;
            s = it.tilt_sine;
            lin = it.linear_accel;
            if (mode_sel == 0)
            begin
                kg = (gain_reg * 10 + 49) / 98;
                a = clamp_w(qmul(gain_reg, s) - qmul(kg, lin));
            end
            else
            begin
                g = G_Q;
                s2 = qmul(s, s);
                m = ONE_I - s2;
                if (m < 0)
                begin
                    m = 0;
                end
                c = root_floor(m << 16);
                if (s2 <= qmul(qmul(mu_reg, mu_reg), m))
                begin
                    a = 0;
                end
                else
                begin
                    fc = qmul(clamp_w(qmul(g, mu_reg)), s < 0 ? -c : c);
                    a = clamp_w(qmul(g, s) - fc);
                end
                a = clamp_w(a - lin);
            end
            v = clamp_w(ball_vel + qmul(dt, half_floor(last_accel + a)));
            x = clamp_w(ball_pos + qmul(dt, half_floor(ball_vel + v)));
            last_accel = a;
            if (x <= 0)
            begin
                if (v < 0)
                begin
                    if (!rest_l && bounce_en != 0)
                    begin
                        r.impact = 1'b1;
                        r.impact_at_left = 1'b1;
                        spd = clamp_w(-v);
                        v = qmul(rest_reg, spd);
                    end
                    else
                    begin
                        v = 0;
                    end
                end
                x = 0;
                rest_l = 1'b1;
                rest_r = 1'b0;
            end
            else if (x >= cav_len)
            begin
                if (v > 0)
                begin
                    if (!rest_r && bounce_en != 0)
                    begin
                        r.impact = 1'b1;
                        spd = v;
                        v = clamp_w(-qmul(rest_reg, v));
                    end
                    else
                    begin
                        v = 0;
                    end
                end
                x = cav_len;
                rest_r = 1'b1;
                rest_l = 1'b0;
            end
            else
            begin
                rest_l = 1'b0;
                rest_r = 1'b0;
            end
            ball_vel = v;
            ball_pos = x;
        end
        r.impact_speed = spd[30:0];
        r.position = ball_pos > 64'hFFFFFF ? 24'hFFFFFF : ball_pos[23:0];
        r.velocity = ball_vel[31:0];
        return r;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.operation <= OP_TICK;
            in_ch.time_step <= '0;
            in_ch.tilt_sine <= '0;
            in_ch.linear_accel <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_states.push_back(step_ball(pending_items.pop_front()));
            end
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.operation <= pending_items[0].operation;
                    in_ch.time_step <= pending_items[0].time_step;
                    in_ch.tilt_sine <= pending_items[0].tilt_sine;
                    in_ch.linear_accel <= pending_items[0].linear_accel;
                    if (!idle_off && $urandom_range(0, 5) == 0)
                    begin
                        send_gap <= $urandom_range(1, 11);
                    end
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        ball_state_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_states.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (out_ch.impact !== want.impact)
                    begin
                        $error("impact exp %0d got %0d", want.impact, out_ch.impact);
                        fail_count++;
                    end
                    if (out_ch.impact_at_left !== want.impact_at_left)
                    begin
                        $error("impact_at_left exp %0d got %0d", want.impact_at_left,
                               out_ch.impact_at_left);
                        fail_count++;
                    end
                    if (out_ch.impact_speed !== want.impact_speed)
                    begin
                        $error("impact_speed exp %0d got %0d", want.impact_speed,
                               out_ch.impact_speed);
                        fail_count++;
                    end
                    if (out_ch.position !== want.position)
                    begin
                        $error("position exp %0d got %0d", want.position, out_ch.position);
                        fail_count++;
                    end
                    if (out_ch.velocity !== want.velocity)
                    begin
                        $error("velocity exp %0d got %0d", want.velocity, out_ch.velocity);
                        fail_count++;
                    end
                end
            end
            if (long_hold > 0)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!idle_off && $urandom_range(0, 4) == 0)
                begin
                    recv_gap <= $urandom_range(1, 11);
                end
            end
        end
    end

    // long receiver hold-off counted in cycles, started on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            long_hold <= HOLD_CYCLES;
        end
        else if (long_hold > 0)
        begin
            long_hold <= long_hold - 1;
        end
    end

    function automatic tick_item_t make_tick(logic [15:0] dt, logic signed [17:0] s,
                                             logic signed [31:0] lin);
        tick_item_t t;
        t.operation = OP_TICK;
        t.time_step = dt;
        t.tilt_sine = s;
        t.linear_accel = lin;
        return t;
    endfunction

    function automatic tick_item_t random_item();
        tick_item_t t;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
        begin
            t = make_tick('0, '0, '0);
            t.operation = OP_RESTART;
            t.time_step = 16'($urandom);
            t.tilt_sine = 18'($urandom);
            t.linear_accel = $urandom;
        end
        else if (sel < 80)
        begin
            // realistic physics with modest steps
            t = make_tick(16'($urandom_range(0, 6000)),
                          18'($signed($urandom_range(0, 131072)) - 65536),
                          $signed($urandom_range(0, 1 << 20)) - (1 << 19));
        end
        else
        begin
            // anything the fields allow
            t = make_tick(16'($urandom), 18'($urandom), $urandom);
        end
        return t;
    endfunction

    task automatic drain();
        while (pending_items.size() != 0 || expected_states.size() != 0 || in_ch.valid)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic run_random(int n);
        repeat (n)
        begin
            pending_items.push_back(random_item());
        end
        drain();
    endtask

    // stimulus
    initial
    begin
        idle_off = 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_CAVITY;
        cfg.data <= '0;
        cav_len = 65536;
        mode_sel = 0;
        bounce_en = 1;
        gain_reg = 458752;
        mu_reg = 19661;
        rest_reg = 32768;
        restart_ball();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, both operations, walls, sine beyond one
        pending_items.push_back(make_tick(16'hFFFF, 18'sd65536, 32'sd0));
        pending_items.push_back(make_tick(16'hFFFF, 18'sd65536, 32'sd0));
        pending_items.push_back(make_tick(16'hFFFF, -18'sd65536, 32'sd0));
        pending_items.push_back(make_tick(16'hFFFF, -18'sd65536, 32'sd0));
        pending_items.push_back(make_tick(16'hFFFF, -18'sd65536, 32'sd0));
        pending_items.push_back(make_tick(16'hFFFF, 18'sh1FFFF, 32'h7FFFFFFF));
        pending_items.push_back(make_tick(16'hFFFF, 18'sh20000, 32'h80000000));
        pending_items.push_back(make_tick('0, '0, '0));
        pending_items.push_back(make_tick(16'd100, 18'sd1000, -32'sd1));
        begin
            tick_item_t t;
            t = make_tick(16'hFFFF, 18'sh3FFFF, 32'hFFFFFFFF);
            t.operation = OP_RESTART;
            pending_items.push_back(t);
        end
        drain();

        // sliding with stiction and friction, long receiver hold-off
        write_register(REG_MODE, 1);
        write_register(REG_MU, 131072);
        pending_items.push_back(make_tick(16'd3000, 18'sd20000, 32'sd0));
        pending_items.push_back(make_tick(16'd3000, 18'sd65536, 32'sd0));
        pending_items.push_back(make_tick(16'd3000, 18'sd90000, 32'sd5000));
        pending_items.push_back(make_tick(16'd3000, -18'sd70000, -32'sd5000));
        hold_req++;
        run_random(40);
        write_register(REG_MU, 0);
        run_random(40);

        // stop at walls, long cavity, strong gain
        write_register(REG_MODE, 0);
        write_register(REG_REBOUND, 0);
        write_register(REG_CAVITY, 8388608);
        write_register(REG_GAIN, 2097152);
        write_register(REG_REST, 65536);
        run_random(60);

        // tiny and zero cavity, bounce above unity
        write_register(REG_REBOUND, 1);
        write_register(REG_CAVITY, 1);
        write_register(REG_REST, 32'h1FFFF);
        run_random(30);
        write_register(REG_CAVITY, 0);
        run_random(20);

        // out of range writes and an unused index
        write_register(REG_CAVITY, 32'hFFFFFFFF);
        write_register(REG_GAIN, 0);
        write_register(REG_REST, 0);
        write_register(REG_NONE, 32'h12345678);
        run_random(50);

        // typical settings, sliding, then rolling without idling
        write_register(REG_CAVITY, 65536);
        write_register(REG_GAIN, 458752);
        write_register(REG_MU, 19661);
        write_register(REG_REST, 32768);
        write_register(REG_MODE, 1);
        run_random(100);
        write_register(REG_MODE, 0);
        idle_off = 1'b1;
        run_random(100);

        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
